// ===== hdl/mhpq_pkg.sv =====
// Package with shared codes, fixed field widths and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int MODE_W    = 2;
  localparam int ID_W      = 8;
  localparam int KEY_W     = 32;
  localparam int CNT_OUT_W = 9;
  localparam int STATUS_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAISE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ID_BAD = 2'd3;

  typedef struct packed {
    logic                latch;
    logic                ins_start;
    logic                raise_start;
    logic                ext_rd;
    logic                ext_take;
    logic                res_zero;
    logic                up_rd;
    logic                up_step;
    logic                dn_rd;
    logic                dn_step;
    logic                write_e;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } mhpq_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              id_ok;
    logic              known;
    logic              full;
    logic              empty;
    logic              slot_ok;
    logic              fill_one;
    logic              p_zero;
    logic              up_gt;
    logic              l_ok;
    logic              best_none;
    logic              out_free;
  } mhpq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mhpq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output      logic [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output      logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/mhpq_ctrl.sv =====
// Controller state machine that sequences insert, extract and raise-key operations.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire mhpq_pkg::mhpq_stat_t st,
  output      mhpq_pkg::mhpq_cmd_t  cmd
);
  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SLOT = 4'd2;
  localparam logic [3:0] S_EXR  = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_UPC  = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_DNC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    code_nxt       = code_r;
    cmd.out_status = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        code_nxt  = ST_OK;
        state_nxt = S_FIN;
        case (st.mode)
          MODE_INSERT: begin
            if (!st.id_ok || st.known) begin
              code_nxt = ST_ID_BAD;
            end else if (st.full) begin
              code_nxt = ST_FULL;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_UP;
            end
          end
          MODE_EXTRACT: begin
            if (st.empty) begin
              code_nxt     = ST_EMPTY;
              cmd.res_zero = 1'b1;
            end else begin
              cmd.ext_rd = 1'b1;
              state_nxt  = S_EXR;
            end
          end
          MODE_RAISE: begin
            if (!st.known) begin
              code_nxt = ST_ID_BAD;
            end else begin
              state_nxt = S_SLOT;
            end
          end
          default: begin
            code_nxt = ST_OK;
          end
        endcase
      end
      S_SLOT: begin
        if (st.slot_ok) begin
          cmd.raise_start = 1'b1;
          state_nxt       = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXR: begin
        cmd.ext_take = 1'b1;
        state_nxt    = st.fill_one ? S_FIN : S_DN;
      end
      S_UP: begin
        if (st.p_zero) begin
          cmd.write_e = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        if (st.up_gt) begin
          cmd.up_step = 1'b1;
          state_nxt   = S_UP;
        end else begin
          cmd.write_e = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_DN: begin
        if (!st.l_ok) begin
          cmd.write_e = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DNC;
        end
      end
      S_DNC: begin
        if (st.best_none) begin
          cmd.write_e = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.dn_step = 1'b1;
          state_nxt   = S_DN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mhpq_dp.sv =====
// Datapath with heap and slot memories, presence bits, sift registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_dp #(
  parameter int CAPACITY = 256,
  parameter int ID_SPACE = 256,
  parameter int KEY_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [mhpq_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [mhpq_pkg::ID_W-1:0]          in_item_id,
  input  wire logic [mhpq_pkg::KEY_W-1:0]         in_new_key,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [mhpq_pkg::STATUS_W-1:0]      out_status,
  output      logic [mhpq_pkg::ID_W-1:0]          out_out_id,
  output      logic [mhpq_pkg::KEY_W-1:0]         out_out_key,
  output      logic [mhpq_pkg::CNT_OUT_W-1:0]     out_entry_count,
  input  wire mhpq_pkg::mhpq_cmd_t                cmd,
  output      mhpq_pkg::mhpq_stat_t               st
);
  import mhpq_pkg::*;

  localparam int KW       = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int EW       = KW + ID_W;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DW       = SLOT_W + 2;
  localparam int ID_DEPTH = (ID_SPACE < (1 << ID_W)) ? ID_SPACE : (1 << ID_W);
  localparam int ID_IW    = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;

  logic [MODE_W-1:0]   mode_r;
  logic [ID_W-1:0]     id_r;
  logic [KW-1:0]       key_r;
  logic [KW-1:0]       e_key_r;
  logic [ID_W-1:0]     e_id_r;
  logic [SLOT_W-1:0]   p_r;
  logic [CNT_W-1:0]    fill_r;
  logic [ID_DEPTH-1:0] present_r;
  logic [ID_W-1:0]     res_id_r;
  logic [KW-1:0]       res_key_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic [SLOT_W-1:0] parent;
  logic [DW-1:0]     l_idx, r_idx, fill_w;
  logic              l_ok, r_ok, sel_l, sel_r;
  logic [KW-1:0]     best_key;
  logic [SLOT_W-1:0] rd_addr_a, rd_addr_b;
  logic [EW-1:0]     rd_a, rd_b;
  logic              h_we;
  logic [EW-1:0]     h_wdata;
  logic [SLOT_W-1:0] slot_rd;
  logic [ID_IW-1:0]  id_idx;

  assign id_idx = id_r[ID_IW-1:0];
  assign parent = SLOT_W'((p_r - SLOT_W'(1)) >> 1);
  assign l_idx  = {1'b0, p_r, 1'b1};
  assign r_idx  = l_idx + DW'(1);
  assign fill_w = DW'(fill_r);
  assign l_ok   = l_idx < fill_w;
  assign r_ok   = r_idx < fill_w;

  assign sel_l    = l_ok && (rd_a[KW-1:0] > e_key_r);
  assign best_key = sel_l ? rd_a[KW-1:0] : e_key_r;
  assign sel_r    = r_ok && (rd_b[KW-1:0] > best_key);

  always_comb begin
    rd_addr_a = parent;
    rd_addr_b = parent;
    if (cmd.ext_rd) begin
      rd_addr_a = '0;
      rd_addr_b = SLOT_W'(fill_r - CNT_W'(1));
    end else if (cmd.dn_rd) begin
      rd_addr_a = l_idx[SLOT_W-1:0];
      rd_addr_b = r_idx[SLOT_W-1:0];
    end
  end

  assign h_we = cmd.write_e | cmd.up_step | cmd.dn_step;

  always_comb begin
    if (cmd.write_e) begin
      h_wdata = {e_id_r, e_key_r};
    end else if (cmd.dn_step && sel_r) begin
      h_wdata = rd_b;
    end else begin
      h_wdata = rd_a;
    end
  end

  mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk     (clk),
    .we      (h_we),
    .waddr   (p_r),
    .wdata   (h_wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_b)
  );

  mhpq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_DEPTH)) u_slot_ram (
    .clk     (clk),
    .we      (h_we),
    .waddr   (h_wdata[KW +: ID_IW]),
    .wdata   (p_r),
    .raddr_a (id_idx),
    .rdata_a (slot_rd),
    .raddr_b (id_idx),
    .rdata_b ()
  );

  always_comb begin
    st           = '0;
    st.mode      = mode_r;
    st.id_ok     = 32'(id_r) < ID_SPACE;
    st.known     = st.id_ok && present_r[id_idx];
    st.full      = fill_r == CNT_W'(CAPACITY);
    st.empty     = fill_r == '0;
    st.slot_ok   = CNT_W'(slot_rd) < fill_r;
    st.fill_one  = fill_r == CNT_W'(1);
    st.p_zero    = p_r == '0;
    st.up_gt     = e_key_r > rd_a[KW-1:0];
    st.l_ok      = l_ok;
    st.best_none = !sel_l && !sel_r;
    st.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r    <= in_mode;
      id_r      <= in_item_id;
      key_r     <= in_new_key[KW-1:0];
      res_id_r  <= in_item_id;
      res_key_r <= in_new_key[KW-1:0];
    end
    if (cmd.res_zero) begin
      res_id_r  <= '0;
      res_key_r <= '0;
    end
    if (cmd.ext_take) begin
      res_id_r  <= rd_a[KW +: ID_W];
      res_key_r <= rd_a[KW-1:0];
      e_id_r    <= rd_b[KW +: ID_W];
      e_key_r   <= rd_b[KW-1:0];
      p_r       <= '0;
    end
    if (cmd.ins_start) begin
      e_id_r  <= id_r;
      e_key_r <= key_r;
      p_r     <= fill_r[SLOT_W-1:0];
    end
    if (cmd.raise_start) begin
      e_id_r  <= id_r;
      e_key_r <= key_r;
      p_r     <= slot_rd;
    end
    if (cmd.up_step) begin
      p_r <= parent;
    end
    if (cmd.dn_step) begin
      p_r <= sel_r ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_id_r     <= res_id_r;
      out_key_r    <= KEY_W'(res_key_r);
      out_cnt_r    <= CNT_OUT_W'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_start) begin
        fill_r            <= fill_r + CNT_W'(1);
        present_r[id_idx] <= 1'b1;
      end
      if (cmd.ext_take) begin
        fill_r                           <= fill_r - CNT_W'(1);
        present_r[rd_a[KW +: ID_IW]] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_out_id      = out_id_r;
  assign out_out_key     = out_key_r;
  assign out_entry_count = out_cnt_r;

endmodule

`default_nettype wire

// ===== hdl/max_heap_priority_queue_top.sv =====
// Top level of the binary max-heap priority queue.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    in_mode, in_item_id, in_new_key
//   out_     output     out_valid/out_ready  out_status, out_out_id, out_out_key,
//                                            out_entry_count
//
// One transaction is processed at a time. Insert and raise-key move the entry up
// the heap, and extract moves the last entry down from the root, by L heap levels
// (at most log2(CAPACITY)). Each level costs one read and one compare-and-write on
// the single heap memory. Reset is synchronous and needs no clearing pass.
// A new transaction is accepted while a result waits on out_.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_top #(
  parameter int CAPACITY = 256,
  parameter int ID_SPACE = 256,
  parameter int KEY_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [mhpq_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [mhpq_pkg::ID_W-1:0]      in_item_id,
  input  wire logic [mhpq_pkg::KEY_W-1:0]     in_new_key,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [mhpq_pkg::STATUS_W-1:0]  out_status,
  output      logic [mhpq_pkg::ID_W-1:0]      out_out_id,
  output      logic [mhpq_pkg::KEY_W-1:0]     out_out_key,
  output      logic [mhpq_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import mhpq_pkg::*;

  mhpq_cmd_t  cmd;
  mhpq_stat_t st;

  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY),
    .ID_SPACE (ID_SPACE),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_item_id      (in_item_id),
    .in_new_key      (in_new_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_out_id      (out_out_id),
    .out_out_key     (out_out_key),
    .out_entry_count (out_entry_count),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

`default_nettype wire
